### rtl/core/chs_pkg.sv
package chs_pkg;

  localparam int MAX_BUCKETS_DEF = 16;
  localparam int CHAIN_SLOTS_DEF = 8;
  localparam int KEY_BITS_DEF    = 32;

  localparam int KEY_W   = 32;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 5;
  localparam int TOTAL_W = 8;
  localparam int REM_W   = CFG_W + 1;

  localparam logic [CFG_W-1:0]   BUCKET_COUNT_RST = CFG_W'(16);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX        = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_COUNT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } rem_sts_t;

endpackage

### rtl/core/chs_ram.sv
module chs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/chs_rem.sv
module chs_rem #(
  parameter int W = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [W-1:0]              dividend_i,
  input  logic [chs_pkg::CFG_W-1:0] modulus_i,
  output chs_pkg::rem_sts_t         sts_o
);
  import chs_pkg::*;

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic             active_q, active_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [W-1:0]     sh_q, sh_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CFG_W-1:0] mod_q, mod_d;
  logic [REM_W-1:0] trial;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    sh_d     = sh_q;
    rem_d    = rem_q;
    mod_d    = mod_q;
    trial    = {rem_q[REM_W-2:0], sh_q[W-1]};
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      sh_d     = dividend_i;
      rem_d    = '0;
      mod_d    = modulus_i;
    end else if (active_q) begin
      if (trial >= {1'b0, mod_q}) begin
        rem_d = trial - {1'b0, mod_q};
      end else begin
        rem_d = trial;
      end
      sh_d  = sh_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.rem  = rem_q;

endmodule

### rtl/core/chained_hash_set_top.sv
// Hash set of unsigned keys, bucket = key modulo the bucket count register (0 is taken as
// 1 and values above MAX_BUCKETS as MAX_BUCKETS), each bucket a fixed run of CHAIN_SLOTS
// slots in one RAM word per slot ({valid, key}). A command is taken when start_i is high
// and busy_o low; its one result word is shown on the result ports for exactly one cycle
// with valid_o high and cannot be held off. Find, insert and remove first run the key
// through the bit-serial remainder unit (key width KEY_BITS, at most 32), then walk the
// bucket's CHAIN_SLOTS slots through the registered RAM read port, then commit; the count
// command goes straight to commit. After reset the block stays busy while a clearing pass
// writes every slot (MAX_BUCKETS * CHAIN_SLOTS, 128 by default) invalid; bucket count
// writes are taken at any time but should only be made while idle. Keys already stored
// are not rehashed when the bucket count changes.
module chained_hash_set_top #(
  parameter int MAX_BUCKETS = chs_pkg::MAX_BUCKETS_DEF,
  parameter int CHAIN_SLOTS = chs_pkg::CHAIN_SLOTS_DEF,
  parameter int KEY_BITS    = chs_pkg::KEY_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chs_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        start_i,
  input  logic [chs_pkg::CMD_W-1:0]   command_i,
  input  logic [chs_pkg::KEY_W-1:0]   key_i,
  output logic                        busy_o,
  output logic                        valid_o,
  output logic                        present_o,
  output logic [chs_pkg::TOTAL_W-1:0] element_total_o,
  output logic                        overflow_o
);
  import chs_pkg::*;

  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int DEPTH = MAX_BUCKETS * CHAIN_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
  localparam int DW    = KW + 1;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [CFG_W-1:0]   bc_q;
  logic [CFG_W-1:0]   mod_use;
  logic [KW-1:0]      key_q, key_d;
  logic [AW-1:0]      base_q, base_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [SW-1:0]      slot_q, slot_d;
  logic [SW-1:0]      cmp_slot_q, cmp_slot_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               hit_q, hit_d;
  logic [SW-1:0]      hit_slot_q, hit_slot_d;
  logic               free_q, free_d;
  logic [SW-1:0]      free_slot_q, free_slot_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               valid_q, valid_d;
  logic               present_q, present_d;
  logic               ovf_q, ovf_d;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [DW-1:0]      ram_rdata;
  logic               rem_start;
  rem_sts_t           rem_sts;

  always_comb begin
    if (bc_q == '0) begin
      mod_use = CFG_W'(1);
    end else if (int'(bc_q) > MAX_BUCKETS) begin
      mod_use = CFG_W'(MAX_BUCKETS);
    end else begin
      mod_use = bc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= BUCKET_COUNT_RST;
    end else if (cfg_we_i) begin
      bc_q <= cfg_wdata_i;
    end
  end

  chs_rem #(
    .W(KW)
  ) u_chs_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (key_d),
    .modulus_i  (mod_use),
    .sts_o      (rem_sts)
  );

  chs_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_chs_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = base_q + AW'(slot_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    base_d      = base_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    cmp_slot_d  = cmp_slot_q;
    cmp_vld_d   = 1'b0;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    total_d     = total_q;
    valid_d     = 1'b0;
    present_d   = present_q;
    ovf_d       = ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    rem_start   = 1'b0;

    if (cmp_vld_q) begin
      if (ram_rdata[DW-1] && (ram_rdata[KW-1:0] == key_q) && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = cmp_slot_q;
      end
      if (!ram_rdata[DW-1] && !free_q) begin
        free_d      = 1'b1;
        free_slot_d = cmp_slot_q;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        key_d = key_i[KW-1:0];
        if (start_i) begin
          cmd_d  = cmd_e'(command_i);
          hit_d  = 1'b0;
          free_d = 1'b0;
          slot_d = '0;
          if (cmd_e'(command_i) == CMD_COUNT) begin
            state_d = ST_COMMIT;
          end else begin
            rem_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          base_d  = AW'(int'(rem_sts.rem) * CHAIN_SLOTS);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d  = 1'b1;
        cmp_slot_d = slot_q;
        slot_d     = slot_q + 1'b1;
        if (slot_q == SW'(CHAIN_SLOTS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        present_d = hit_q;
        ovf_d     = 1'b0;
        valid_d   = 1'b1;
        state_d   = ST_IDLE;
        case (cmd_q)
          CMD_INSERT: begin
            if (!hit_q) begin
              if (free_q) begin
                ram_we    = 1'b1;
                ram_waddr = base_q + AW'(free_slot_q);
                ram_wdata = {1'b1, key_q};
                if (total_q != TOTAL_MAX) begin
                  total_d = total_q + 1'b1;
                end
              end else begin
                ovf_d = 1'b1;
              end
            end
          end
          CMD_REMOVE: begin
            if (hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = base_q + AW'(hit_slot_q);
              ram_wdata = {1'b0, key_q};
              if (total_q != '0) begin
                total_d = total_q - 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cmp_vld_q <= 1'b0;
      total_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cmp_vld_q <= cmp_vld_d;
      total_q   <= total_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    base_q      <= base_d;
    slot_q      <= slot_d;
    cmp_slot_q  <= cmp_slot_d;
    hit_q       <= hit_d;
    hit_slot_q  <= hit_slot_d;
    free_q      <= free_d;
    free_slot_q <= free_slot_d;
    present_q   <= present_d;
    ovf_q       <= ovf_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign valid_o         = valid_q;
  assign present_o       = present_q;
  assign element_total_o = total_q;
  assign overflow_o      = ovf_q;

endmodule

### rtl/core/chs_checker.sv
module chs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        valid_o,
  input logic                        present_o,
  input logic [chs_pkg::TOTAL_W-1:0] element_total_o,
  input logic                        overflow_o
);
  import chs_pkg::*;

  // hold busy once a word is taken
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy low after a command word was taken");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result word without a command in flight");

  // drop on overflow leaves the count as it was
  a_overflow_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_o |-> !present_o && (element_total_o == $past(element_total_o)))
    else $error("overflow on a present key or with a changed count");

endmodule

bind chained_hash_set_top chs_checker u_chs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .valid_o         (valid_o),
  .present_o       (present_o),
  .element_total_o (element_total_o),
  .overflow_o      (overflow_o)
);
